[sv/nlb_pkg.sv]
package nlb_pkg;

  // cost width of the result fields
  localparam int COST_BITS = 48;
  localparam logic [COST_BITS-1:0] COST_ALL = '1;

  // default window depth and line width after reset
  localparam int          WINDOW_DEF     = 128;
  localparam logic [7:0]  LINE_WIDTH_RST = 8'd80;

  typedef struct packed {
    logic [7:0] word_length;
    logic       ends_paragraph;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           line_words;
    logic [COST_BITS-1:0] prefix_cost;
    logic [7:0]           final_line_words;
    logic [COST_BITS-1:0] final_cost;
    logic                 fits;
  } out_item_t;

endpackage

[sv/neat_line_break_dp.sv]
// The walk back tries L candidate lines, L = min(words since the paragraph start + 1,
// WINDOW); fewer when the last line overflows the width early. A new item is taken
// only after the last result is registered; the candidate walk reads one stored
// length and one stored cost per cycle through a single read port on each ring memory.
// Reset (rst_n low, synchronous): window empty, line_width = 80, no item pending.
// Ring memories are not cleared; a fill count keeps unwritten entries out of the result.
module neat_line_break_dp #(
  parameter int WINDOW = nlb_pkg::WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nlb_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output nlb_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_line_width
);
  import nlb_pkg::*;

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                 state_r;
  logic [7:0]           line_width_r;
  logic [AW-1:0]        ptr_r;
  logic [CW-1:0]        seen_r;

  // per-item working registers
  logic [7:0]           wlen_r;
  logic                 last_r;
  logic [CW-1:0]        limit_r;
  logic                 sat_r;
  logic [AW-1:0]        cur_r;
  logic [CW-1:0]        iss_m_r;
  logic                 iss_done_r;
  logic                 stop_r;

  // fetch stage
  logic                 rd_vld_r;
  logic [CW-1:0]        m1_r;
  logic [7:0]           len_rd_r;
  logic [COST_BITS-1:0] cost_rd_r;
  logic [8:0]           span_r;

  // square and cube stages
  logic                 s1_vld_r;
  logic [7:0]           s1_slack_r;
  logic [15:0]          s1_sq_r;
  logic [COST_BITS-1:0] s1_prior_r;
  logic [CW-1:0]        s1_m_r;
  logic                 s2_vld_r;
  logic [23:0]          s2_cube_r;
  logic [COST_BITS-1:0] s2_prior_r;
  logic [CW-1:0]        s2_m_r;

  // running minima
  logic [COST_BITS-1:0] best_r;
  logic [CW-1:0]        best_m_r;
  logic [COST_BITS-1:0] bfin_r;
  logic [CW-1:0]        bfin_m_r;

  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic [7:0]           len_mem [WINDOW];
  logic [COST_BITS-1:0] cost_mem [WINDOW];

  logic                 accept;
  logic                 issue;
  logic                 done;
  logic [AW-1:0]        cur_dec;
  logic [8:0]           span_new;
  logic                 span_fit;
  logic [7:0]           slack;
  logic                 prior_zero;
  logic [COST_BITS:0]   sum;
  logic [COST_BITS-1:0] cand;
  logic [CW-1:0]        limit_nxt;
  logic [AW-1:0]        ptr_inc;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign accept = in_valid && in_ready;
  assign issue  = (state_r == ST_RUN) && !iss_done_r && !stop_r;
  assign done   = (state_r == ST_RUN) && (iss_done_r || stop_r) && !rd_vld_r &&
                  !s1_vld_r && !s2_vld_r && (!out_valid_r || out_ready);

  assign cur_dec = (cur_r == '0) ? AW'(WINDOW - 1) : cur_r - 1'b1;
  assign ptr_inc = (ptr_r == AW'(WINDOW - 1)) ? '0 : ptr_r + 1'b1;

  assign limit_nxt = (seen_r == CW'(WINDOW)) ? CW'(WINDOW) : seen_r + 1'b1;

  // grow the line by the word fetched for this step and test the width
  assign span_new   = (m1_r == CW'(1)) ? {1'b0, wlen_r}
                                       : span_r + 9'd1 + {1'b0, len_rd_r};
  assign span_fit   = (span_new <= {1'b0, line_width_r});
  assign slack      = line_width_r - span_new[7:0];
  assign prior_zero = !sat_r && (m1_r == limit_r);

  // saturating add of the cube to the earlier prefix cost
  assign sum  = {1'b0, s2_prior_r} + (COST_BITS+1)'(s2_cube_r);
  assign cand = ((s2_prior_r == COST_ALL) || sum[COST_BITS]) ? COST_ALL
                                                             : sum[COST_BITS-1:0];

  // ring memories: one write per item that does not end a paragraph, one read per cycle
  always_ff @(posedge clk) begin
    if (done && !last_r) begin
      len_mem[ptr_r]  <= wlen_r;
      cost_mem[ptr_r] <= best_r;
    end
    len_rd_r  <= len_mem[cur_r];
    cost_rd_r <= cost_mem[cur_dec];
  end

  // sequencer, window bookkeeping and config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      line_width_r <= LINE_WIDTH_RST;
      ptr_r        <= '0;
      seen_r       <= '0;
      iss_done_r   <= 1'b0;
      stop_r       <= 1'b0;
      rd_vld_r     <= 1'b0;
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        line_width_r <= cfg_line_width;
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      // start a walk back over the window
      if (accept) begin
        state_r    <= ST_RUN;
        iss_done_r <= 1'b0;
        stop_r     <= 1'b0;
      end

      // issue one candidate read per cycle
      rd_vld_r <= issue;
      if (issue && (iss_m_r == limit_r)) begin
        iss_done_r <= 1'b1;
      end

      // stop at the first line that overflows
      s1_vld_r <= rd_vld_r && !stop_r && span_fit;
      if (rd_vld_r && !stop_r && !span_fit) begin
        stop_r <= 1'b1;
      end

      s2_vld_r <= s1_vld_r;

      // hand over the result; keep this word in the window unless it ends the paragraph
      if (done) begin
        state_r     <= ST_IDLE;
        out_valid_r <= 1'b1;
        if (last_r) begin
          ptr_r  <= '0;
          seen_r <= '0;
        end else begin
          ptr_r <= ptr_inc;
          if (seen_r != CW'(WINDOW)) begin
            seen_r <= seen_r + 1'b1;
          end
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      wlen_r   <= in_data.word_length;
      last_r   <= in_data.ends_paragraph;
      limit_r  <= limit_nxt;
      sat_r    <= (seen_r == CW'(WINDOW));
      cur_r    <= ptr_r;
      iss_m_r  <= CW'(1);
      best_r   <= COST_ALL;
      best_m_r <= '0;
      bfin_r   <= COST_ALL;
      bfin_m_r <= '0;
    end else begin
      if (issue) begin
        cur_r   <= cur_dec;
        iss_m_r <= iss_m_r + 1'b1;
        m1_r    <= iss_m_r;
      end

      if (rd_vld_r && !stop_r && span_fit) begin
        span_r     <= span_new;
        s1_slack_r <= slack;
        s1_sq_r    <= 16'(slack) * 16'(slack);
        s1_prior_r <= prior_zero ? '0 : cost_rd_r;
        s1_m_r     <= m1_r;
      end

      s2_cube_r  <= 24'(s1_sq_r) * 24'(s1_slack_r);
      s2_prior_r <= s1_prior_r;
      s2_m_r     <= s1_m_r;

      // keep strictly smaller costs so ties hold the shortest line
      if (s2_vld_r) begin
        if (cand < best_r) begin
          best_r   <= cand;
          best_m_r <= s2_m_r;
        end
        if (s2_prior_r < bfin_r) begin
          bfin_r   <= s2_prior_r;
          bfin_m_r <= s2_m_r;
        end
      end
    end

    if (done) begin
      out_data_r.line_words       <= 8'(best_m_r);
      out_data_r.prefix_cost      <= best_r;
      out_data_r.final_line_words <= 8'(bfin_m_r);
      out_data_r.final_cost       <= bfin_r;
      out_data_r.fits             <= (wlen_r <= line_width_r);
    end
  end

endmodule

[sv/nlb_chk.sv]
module nlb_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input nlb_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input nlb_pkg::out_item_t out_data,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [7:0]         cfg_line_width
);
  import nlb_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // a word wider than the line leaves no feasible break
  a_no_fit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fits |->
      out_data.line_words == 8'd0 && out_data.final_line_words == 8'd0 &&
      out_data.prefix_cost == COST_ALL && out_data.final_cost == COST_ALL)
    else $error("overlong word reported as fitting");

  // the free last line never costs more than a charged one
  a_final_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.final_cost <= out_data.prefix_cost)
    else $error("final cost above prefix cost");

endmodule

bind neat_line_break_dp nlb_chk u_nlb_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_data        (in_data),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_data       (out_data),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready),
  .cfg_line_width (cfg_line_width)
);

[dv/neat_line_break_dp_test.sv]
module neat_line_break_dp_test;
  import nlb_pkg::*;

  localparam int WIN = WINDOW_DEF;
  localparam longint unsigned COST_SAT = 64'(COST_ALL);
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int PHASES = 5;
  localparam int PRESSURE_AT = 120;
  localparam int PRESSURE_CYCLES = 400;

  typedef struct {
    in_item_t  stim;
    bit        known;
    out_item_t want;
  } word_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_line_width = LINE_WIDTH_RST;

  // shadow of the line breaker state
  logic [7:0]      len_hist [WIN];
  longint unsigned cost_hist [WIN];
  int unsigned     head;
  int unsigned     words_held;
  logic [7:0]      line_width_q;

  out_item_t   pending_breaks [$];
  word_row_t   plan [$];
  int          errors = 0;
  int          results_seen = 0;
  int          paragraphs = 0;
  int          misfits = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;

  neat_line_break_dp dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_line_width(cfg_line_width)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned back_slot(input int unsigned r);
    return (head + WIN - (r % WIN)) % WIN;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < WIN; i++) begin
      len_hist[i] = '0;
      cost_hist[i] = 0;
    end
    head = 0;
    words_held = 0;
  endfunction

  // Try each last line ending at this word, keep the cheapest; store the word unless it ends a paragraph.
  function automatic out_item_t predict_break(input in_item_t it);
    out_item_t       r;
    int unsigned     lim, span, w, best_m, best_fin_m;
    longint unsigned prior, slack, cube, cand, best, best_fin;
    w = line_width_q;
    lim = (words_held < WIN) ? words_held + 1 : WIN;
    span = it.word_length;
    best = COST_SAT;
    best_fin = COST_SAT;
    best_m = 0;
    best_fin_m = 0;
    for (int unsigned m = 1; m <= lim; m++) begin
      if (m > 1)
        span += 1 + len_hist[back_slot(m - 1)];
      if (span > w)
        break;
      // the line reaching back to the paragraph start has no earlier cost
      if (words_held < WIN && m - 1 == words_held)
        prior = 0;
      else
        prior = cost_hist[back_slot(m)];
      slack = w - span;
      cube = slack * slack * slack;
      if (prior >= COST_SAT || cube >= COST_SAT || prior > COST_SAT - cube)
        cand = COST_SAT;
      else
        cand = prior + cube;
      if (cand < best) begin
        best = cand;
        best_m = m;
      end
      if (prior < best_fin) begin
        best_fin = prior;
        best_fin_m = m;
      end
    end
    r.line_words = 8'(best_m);
    r.prefix_cost = COST_BITS'(best);
    r.final_line_words = 8'(best_fin_m);
    r.final_cost = COST_BITS'(best_fin);
    r.fits = (it.word_length <= line_width_q);
    if (it.ends_paragraph) begin
      clear_window();
    end else begin
      len_hist[head] = it.word_length;
      cost_hist[head] = best;
      head = (head + 1) % WIN;
      if (words_held < WIN)
        words_held++;
    end
    return r;
  endfunction

  function automatic void check_break(input out_item_t got);
    out_item_t want;
    if (pending_breaks.size() == 0) begin
      $error("result arrived with no word pending");
      errors++;
      return;
    end
    want = pending_breaks.pop_front();
    if (got.line_words !== want.line_words) begin
      $error("line_words: expected %0d, got %0d", want.line_words, got.line_words);
      errors++;
    end
    if (got.prefix_cost !== want.prefix_cost) begin
      $error("prefix_cost: expected %0h, got %0h", want.prefix_cost, got.prefix_cost);
      errors++;
    end
    if (got.final_line_words !== want.final_line_words) begin
      $error("final_line_words: expected %0d, got %0d",
             want.final_line_words, got.final_line_words);
      errors++;
    end
    if (got.final_cost !== want.final_cost) begin
      $error("final_cost: expected %0h, got %0h", want.final_cost, got.final_cost);
      errors++;
    end
    if (got.fits !== want.fits) begin
      $error("fits: expected %0b, got %0b", want.fits, got.fits);
      errors++;
    end
  endfunction

  task automatic add_row(input logic [7:0] len, input bit endp, input bit known = 1'b0,
                         input logic [7:0] lw = '0, input logic [COST_BITS-1:0] pc = '0,
                         input logic [7:0] flw = '0, input logic [COST_BITS-1:0] fc = '0,
                         input bit ok = 1'b0);
    word_row_t row;
    row.stim.word_length = len;
    row.stim.ends_paragraph = endp;
    row.known = known;
    row.want.line_words = lw;
    row.want.prefix_cost = pc;
    row.want.final_line_words = flw;
    row.want.final_cost = fc;
    row.want.fits = ok;
    plan.push_back(row);
  endtask

  // Hold the word until taken, record its expected result, then idle for a random gap, which may be zero.
  task automatic offer_word(input in_item_t it, input bit known, input out_item_t want);
    out_item_t pred;
    int        gap;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pred = predict_break(it);
    pending_breaks.push_back(known ? want : pred);
    if (!pred.fits)
      misfits++;
    if (it.ends_paragraph)
      paragraphs++;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain the block, then change the line width.
  task automatic write_width(input logic [7:0] w);
    in_valid <= 1'b0;
    while (pending_breaks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_line_width <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    line_width_q = w;
  endtask

  // Mostly short words that fit, a few of any length; mostly one-letter words when ones_heavy is set.
  function automatic logic [7:0] draw_length(input bit ones_heavy);
    int unsigned pick, w;
    w = line_width_q;
    pick = $urandom_range(0, 9);
    if (ones_heavy && pick < 7)
      return 8'd1;
    if (pick == 0)
      return 8'($urandom_range(1, 255));
    if (pick <= 3)
      return 8'($urandom_range(1, w));
    return 8'($urandom_range(1, (w / 6) + 1));
  endfunction

  // Result side: random stalls per item unless no_idle is set, one long hold-off to back up the input.
  initial begin : result_side
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        check_break(out_data);
        results_seen++;
        stall = no_idle ? 0 : $urandom_range(0, 4);
        if (results_seen == PRESSURE_AT)
          stall = PRESSURE_CYCLES;
      end else if (stall > 0) begin
        stall--;
      end
      out_ready <= (stall == 0);
    end
  end

  initial begin : word_side
    logic [7:0] phase_width [PHASES];
    int         phase_items [PHASES];
    in_item_t   it;
    int         para_left;
    bit         all_ones;
    clear_window();
    line_width_q = LINE_WIDTH_RST;
    phase_width = '{8'd255, 8'd1, 8'd40, 8'($urandom_range(2, 254)), 8'd128};
    phase_items = '{170, 40, 80, 80, 80};

    // directed words at the reset width of 80
    add_row(8'd80, 1'b0, 1'b1, 8'd1, '0, 8'd1, '0, 1'b1);
    add_row(8'd81, 1'b1, 1'b1, 8'd0, COST_ALL, 8'd0, COST_ALL, 1'b0);
    add_row(8'd255, 1'b1, 1'b1, 8'd0, COST_ALL, 8'd0, COST_ALL, 1'b0);
    add_row(8'd1, 1'b0, 1'b1, 8'd1, 48'd493039, 8'd1, '0, 1'b1);
    add_row(8'd79, 1'b0);
    add_row(8'd1, 1'b1);
    // an overlong word poisons every line that starts after it
    add_row(8'd5, 1'b0);
    add_row(8'd100, 1'b0);
    add_row(8'd5, 1'b0, 1'b1, 8'd0, COST_ALL, 8'd0, COST_ALL, 1'b1);
    add_row(8'd70, 1'b0);
    add_row(8'd3, 1'b1);
    // ordinary paragraph with an exact two-word fit and a late overlong word
    add_row(8'd39, 1'b0);
    add_row(8'd40, 1'b0);
    add_row(8'd20, 1'b0);
    add_row(8'd20, 1'b0);
    add_row(8'd19, 1'b0);
    add_row(8'd128, 1'b0);
    add_row(8'd1, 1'b0);
    add_row(8'd2, 1'b1);

    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i])
      offer_word(plan[i].stim, plan[i].known, plan[i].want);

    // random phases; the first opens with a long paragraph of one-letter words
    para_left = 150;
    all_ones = 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      write_width(phase_width[p]);
      no_idle = (p == 2);
      for (int k = 0; k < phase_items[p]; k++) begin
        it.ends_paragraph = (para_left <= 1);
        it.word_length = all_ones ? 8'd1 : draw_length(p == 0);
        offer_word(it, 1'b0, '0);
        if (it.ends_paragraph) begin
          para_left = ($urandom_range(0, 7) == 0) ? $urandom_range(130, 170)
                                                 : $urandom_range(1, 15);
          all_ones = (p == 0) && ($urandom_range(0, 1) == 1);
        end else begin
          para_left--;
        end
      end
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (pending_breaks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Checked %0d line-break results over %0d paragraphs at %0d line widths.",
             results_seen, paragraphs, PHASES + 1);
    $display("%0d words were too long for their line; %0d mismatches.", misfits, errors);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
